FILE: rtl/core/i2cblm_pkg.sv
`default_nettype none
// ============================================================================
// i2cblm_pkg
// Shared types and constants for the bit-level I2C master core.
// ============================================================================
package i2cblm_pkg;

    localparam int DELAY_BITS = 16;
    localparam int HP_W       = 16;

    localparam logic [HP_W-1:0] HALF_PERIOD_RESET = 16'd50;
    localparam logic [3:0]      BITS_PER_BYTE     = 4'd8;

    // command codes carried in the mode field
    localparam logic [2:0] MODE_NONE      = 3'd0;
    localparam logic [2:0] MODE_START     = 3'd1;
    localparam logic [2:0] MODE_STOP      = 3'd2;
    localparam logic [2:0] MODE_WRITE     = 3'd3;
    localparam logic [2:0] MODE_READ_ACK  = 3'd4;
    localparam logic [2:0] MODE_READ_NACK = 3'd5;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'd0,
        PH_ST_A   = 5'd1,
        PH_ST_B   = 5'd2,
        PH_ST_C   = 5'd3,
        PH_ST_D   = 5'd4,
        PH_SP_A   = 5'd5,
        PH_SP_B   = 5'd6,
        PH_SP_C   = 5'd7,
        PH_SP_D   = 5'd8,
        PH_SP_E   = 5'd9,
        PH_WR_A   = 5'd10,
        PH_WR_BIT = 5'd11,
        PH_WR_HI  = 5'd12,
        PH_WR_LO  = 5'd13,
        PH_WR_REL = 5'd14,
        PH_WR_AHI = 5'd15,
        PH_WR_ALO = 5'd16,
        PH_RD_A   = 5'd17,
        PH_RD_HI  = 5'd18,
        PH_RD_LO  = 5'd19,
        PH_RD_ACK = 5'd20,
        PH_RD_AHI = 5'd21,
        PH_RD_ALO = 5'd22,
        PH_FIN    = 5'd23
    } t_phase;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] write_byte;
        logic       sda_in;
    } t_cmd;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_released;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_seen;
    } t_result;

    // delay counter load: zero counts as one tick, clamp to counter range
    function automatic logic [DELAY_BITS-1:0] delay_load(input logic [HP_W-1:0] hp);
        logic [HP_W-1:0] m1;
        logic [32:0]     ext;
        m1  = (hp == '0) ? '0 : hp - 1'b1;
        ext = 33'(m1);
        if (ext > ((33'd1 << DELAY_BITS) - 33'd1)) begin
            return '1;
        end
        return DELAY_BITS'(m1);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/i2cblm_in_reg.sv
`default_nettype none
// ============================================================================
// i2cblm_in_reg
// Input register: holds one tick item until the sequencer takes it.
// ============================================================================
module i2cblm_in_reg (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  i2cblm_pkg::t_cmd    i_cmd,
    input  wire                 i_take,
    output logic                o_valid,
    output i2cblm_pkg::t_cmd    o_cmd
);
    import i2cblm_pkg::*;

    logic r_valid;
    t_cmd r_cmd;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd <= i_cmd;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/i2cblm_seq.sv
`default_nettype none
// ============================================================================
// i2cblm_seq
// Bit-level sequencer: one step of the START/STOP/WRITE/READ phases per item.
// ============================================================================
module i2cblm_seq (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_step,
    input  i2cblm_pkg::t_cmd                      i_cmd,
    input  wire [i2cblm_pkg::HP_W-1:0]            i_half_period,
    output i2cblm_pkg::t_result                   o_res
);
    import i2cblm_pkg::*;

    t_phase                r_phase,   n_phase;
    logic [3:0]            r_bit_cnt, n_bit_cnt;
    logic [7:0]            r_shift,   n_shift;
    logic [DELAY_BITS-1:0] r_delay,   n_delay;
    logic                  r_scl,     n_scl;
    logic                  r_sda,     n_sda;
    logic                  r_ack,     n_ack;
    logic                  r_nack,    n_nack;
    logic                  r_dir,     n_dir;
    logic                  r_waiting, n_waiting;
    logic [7:0]            r_read,    n_read;
    logic                  step_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_bit_cnt <= '0;
            r_shift   <= '0;
            r_delay   <= '0;
            r_scl     <= 1'b0;
            r_sda     <= 1'b0;
            r_ack     <= 1'b0;
            r_nack    <= 1'b0;
            r_dir     <= 1'b0;
            r_waiting <= 1'b0;
            r_read    <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_bit_cnt <= n_bit_cnt;
            r_shift   <= n_shift;
            r_delay   <= n_delay;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
            r_ack     <= n_ack;
            r_nack    <= n_nack;
            r_dir     <= n_dir;
            r_waiting <= n_waiting;
            r_read    <= n_read;
        end
    end

    // next state
    always_comb begin
        t_phase                p;
        logic [DELAY_BITS-1:0] load;
        logic [3:0]            cnt_inc;
        p         = r_phase;
        load      = delay_load(i_half_period);
        n_bit_cnt = r_bit_cnt;
        n_shift   = r_shift;
        n_delay   = r_delay;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_ack     = r_ack;
        n_nack    = r_nack;
        n_dir     = r_dir;
        n_waiting = r_waiting;
        n_read    = r_read;
        step_done = 1'b0;

        // command decode, only when idle
        if (r_phase == PH_IDLE) begin
            priority if (i_cmd.mode == MODE_START) begin
                p = PH_ST_A;
            end else if (i_cmd.mode == MODE_STOP) begin
                p = PH_SP_A;
            end else if (i_cmd.mode == MODE_WRITE) begin
                n_shift   = i_cmd.write_byte;
                n_bit_cnt = '0;
                p         = PH_WR_A;
            end else if (i_cmd.mode == MODE_READ_ACK || i_cmd.mode == MODE_READ_NACK) begin
                n_nack = (i_cmd.mode == MODE_READ_NACK);
                p      = PH_RD_A;
            end else begin
                p = PH_IDLE;
            end
        end

        cnt_inc = 4'(n_bit_cnt + 4'd1);

        if (r_waiting) begin
            if (r_delay == '0) begin
                n_waiting = 1'b0;
                if (p == PH_FIN) begin
                    p         = PH_IDLE;
                    step_done = 1'b1;
                end
            end else begin
                n_delay = r_delay - 1'b1;
            end
        end else begin
            unique case (p)
                PH_ST_A:   begin n_dir = 1'b0; n_sda = 1'b1; p = PH_ST_B; end
                PH_ST_B:   begin n_scl = 1'b1; n_delay = load; n_waiting = 1'b1; p = PH_ST_C; end
                PH_ST_C:   begin n_sda = 1'b0; p = PH_ST_D; end
                PH_ST_D:   begin n_scl = 1'b0; p = PH_IDLE; step_done = 1'b1; end
                PH_SP_A:   begin n_dir = 1'b0; n_sda = 1'b0; p = PH_SP_B; end
                PH_SP_B:   begin n_scl = 1'b1; n_delay = load; n_waiting = 1'b1; p = PH_SP_C; end
                PH_SP_C:   begin n_sda = 1'b1; p = PH_SP_D; end
                PH_SP_D:   begin n_scl = 1'b0; n_delay = load; n_waiting = 1'b1; p = PH_SP_E; end
                PH_SP_E:   begin n_scl = 1'b1; p = PH_IDLE; step_done = 1'b1; end
                PH_WR_A:   begin n_dir = 1'b0; n_scl = 1'b0; p = PH_WR_BIT; end
                PH_WR_BIT: begin
                    n_sda = n_shift[7];
                    n_delay = load; n_waiting = 1'b1; p = PH_WR_HI;
                end
                PH_WR_HI:  begin n_scl = 1'b1; n_delay = load; n_waiting = 1'b1; p = PH_WR_LO; end
                PH_WR_LO:  begin
                    n_scl     = 1'b0;
                    n_shift   = {n_shift[6:0], 1'b0};
                    n_bit_cnt = cnt_inc;
                    p         = (cnt_inc >= BITS_PER_BYTE) ? PH_WR_REL : PH_WR_BIT;
                end
                PH_WR_REL: begin n_dir = 1'b1; n_delay = load; n_waiting = 1'b1; p = PH_WR_AHI; end
                PH_WR_AHI: begin n_scl = 1'b1; n_delay = load; n_waiting = 1'b1; p = PH_WR_ALO; end
                PH_WR_ALO: begin
                    n_ack = !i_cmd.sda_in;
                    n_scl = 1'b0;
                    n_delay = load; n_waiting = 1'b1; p = PH_FIN;
                end
                PH_RD_A:   begin
                    n_dir     = 1'b1;
                    n_scl     = 1'b0;
                    n_shift   = '0;
                    n_bit_cnt = '0;
                    n_delay = load; n_waiting = 1'b1; p = PH_RD_HI;
                end
                PH_RD_HI:  begin n_scl = 1'b1; n_delay = load; n_waiting = 1'b1; p = PH_RD_LO; end
                PH_RD_LO:  begin
                    n_shift   = {n_shift[6:0], i_cmd.sda_in};
                    n_scl     = 1'b0;
                    n_bit_cnt = cnt_inc;
                    n_delay   = load;
                    n_waiting = 1'b1;
                    p         = (cnt_inc >= BITS_PER_BYTE) ? PH_RD_ACK : PH_RD_HI;
                end
                PH_RD_ACK: begin
                    n_dir = 1'b0;
                    n_sda = n_nack;
                    n_delay = load; n_waiting = 1'b1; p = PH_RD_AHI;
                end
                PH_RD_AHI: begin n_scl = 1'b1; n_delay = load; n_waiting = 1'b1; p = PH_RD_ALO; end
                PH_RD_ALO: begin
                    n_scl     = 1'b0;
                    n_read    = n_shift;
                    p         = PH_IDLE;
                    step_done = 1'b1;
                end
                PH_FIN:    begin p = PH_IDLE; step_done = 1'b1; end
                default:   p = PH_IDLE;
            endcase
        end
        n_phase = p;
    end

    // outputs: levels after this tick's update
    always_comb begin
        o_res.scl_level    = n_scl;
        o_res.sda_level    = n_sda;
        o_res.sda_released = n_dir;
        o_res.busy_res     = (n_phase != PH_IDLE);
        o_res.done_res     = step_done;
        o_res.read_byte    = n_read;
        o_res.ack_seen     = n_ack;
    end

endmodule
`default_nettype wire

FILE: rtl/core/i2cblm_out_reg.sv
`default_nettype none
// ============================================================================
// i2cblm_out_reg
// Result register: holds one result item until the receiver takes it.
// ============================================================================
module i2cblm_out_reg (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_load,
    input  i2cblm_pkg::t_result  i_res,
    output logic                 o_free,
    output logic                 o_valid,
    input  wire                  i_ready,
    output i2cblm_pkg::t_result  o_res
);
    import i2cblm_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/i2c_bit_level_master_core.sv
`default_nettype none
// ============================================================================
// i2c_bit_level_master_core
// Bit-level I2C master sequencer, one tick item in, one result item out.
// ============================================================================
// Usage:
//  - Input channel (i_in_valid / o_in_ready): one item per bus tick, carrying
//    i_mode (none, start, stop, write, read+ACK, read+NACK), i_write_byte and
//    the sampled SDA level i_sda_in. Commands given while busy are ignored.
//  - Output channel (o_out_valid / i_out_ready): one result item per input
//    item: SCL/SDA drive levels, SDA direction, busy, done pulse, last read
//    byte and the last write's sampled acknowledge.
//  - Config channel (i_cfg_valid / o_cfg_ready): writes half_period, the tick
//    count of each delay phase (zero acts as one). Always ready; write only
//    while idle.
//  - Flow: an accepted item lands in the input register, and its result is
//    registered in the result register once that slot is free. Throughput is
//    one item per cycle while the receiver does not stall, set by the single
//    step of the sequencer between input and result registers.
//  - Stall: if the receiver holds off, the result register keeps its item,
//    the input register fills, then o_in_ready drops; nothing is lost.
//  - Reset (synchronous, active low): both channels empty, sequencer idle,
//    SCL and SDA drive low, half_period back to 50.
// ============================================================================
module i2c_bit_level_master_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // tick items
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  wire  [2:0] i_mode,
    input  wire  [7:0] i_write_byte,
    input  wire        i_sda_in,
    // result items
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output logic       o_scl_level,
    output logic       o_sda_level,
    output logic       o_sda_released,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [7:0] o_read_byte,
    output logic       o_ack_seen,
    // configuration
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire [15:0] i_cfg_half_period
);
    import i2cblm_pkg::*;

    t_cmd            in_cmd;
    t_cmd            stage_cmd;
    logic            stage_valid;
    logic            out_free;
    logic            advance;
    t_result         step_res;
    t_result         out_res;
    logic [HP_W-1:0] r_half_period;

    // config register, always accepting
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_half_period <= i_cfg_half_period;
        end
    end

    assign in_cmd.mode       = i_mode;
    assign in_cmd.write_byte = i_write_byte;
    assign in_cmd.sda_in     = i_sda_in;

    // a held item steps the sequencer once the result slot can take it
    assign advance = stage_valid && out_free;

    i2cblm_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_cmd   (in_cmd),
        .i_take  (advance),
        .o_valid (stage_valid),
        .o_cmd   (stage_cmd)
    );

    i2cblm_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_cmd         (stage_cmd),
        .i_half_period (r_half_period),
        .o_res         (step_res)
    );

    i2cblm_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance),
        .i_res   (step_res),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (out_res)
    );

    assign o_scl_level    = out_res.scl_level;
    assign o_sda_level    = out_res.sda_level;
    assign o_sda_released = out_res.sda_released;
    assign o_busy_res     = out_res.busy_res;
    assign o_done_res     = out_res.done_res;
    assign o_read_byte    = out_res.read_byte;
    assign o_ack_seen     = out_res.ack_seen;

endmodule
`default_nettype wire

FILE: rtl/core/i2cblm_checker.sv
`default_nettype none
// ============================================================================
// i2cblm_checker
// Port-level checks for the bit-level I2C master core, bound to the top.
// ============================================================================
module i2cblm_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       o_in_ready,
    input wire [2:0] i_mode,
    input wire [7:0] i_write_byte,
    input wire       i_sda_in,
    input wire       o_out_valid,
    input wire       i_out_ready,
    input wire       o_scl_level,
    input wire       o_sda_level,
    input wire       o_sda_released,
    input wire       o_busy_res,
    input wire       o_done_res,
    input wire [7:0] o_read_byte,
    input wire       o_ack_seen,
    input wire       i_cfg_valid,
    input wire       o_cfg_ready,
    input wire [15:0] i_cfg_half_period
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_byte)
            && $stable(o_scl_level) && $stable(o_sda_level) && $stable(o_done_res))
        else $error("result changed while stalled");

    // a completing command leaves the sequencer idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res)
        else $error("done with busy still set");

    // input side only blocks when the result slot is full and stalled
    a_in_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid || i_out_ready |-> o_in_ready)
        else $error("input stalled while output can drain");

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind i2c_bit_level_master_core i2cblm_checker u_i2cblm_checker (.*);
`default_nettype wire
